### sv/tls_pkg.sv
// Package for the two-way traffic light sequencer.
// Holds the phase type, register indexes, reset values and lamp patterns.
// No dependencies; every module of the block imports it.
`default_nettype none

package tls_pkg;

    localparam int unsigned MS_W      = 16;
    localparam int unsigned DIV_W     = 8;
    localparam int unsigned PORT_BC_W = 6;
    localparam int unsigned PORT_D_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [MS_W-1:0]  GREEN_MS_RST      = 16'd4000;
    localparam logic [MS_W-1:0]  AMBER_MS_RST      = 16'd2000;
    localparam logic [DIV_W-1:0] BLINK_COMPARE_RST = 8'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_MS      = 2'd0,
        CFG_AMBER_MS      = 2'd1,
        CFG_BLINK_COMPARE = 2'd2
    } t_cfg_idx;

    // Road A green is the state reached after reset; handover precedes it.
    typedef enum logic [2:0] {
        S_A_GREEN,
        S_A_AMBER,
        S_B_GREEN,
        S_B_AMBER,
        S_HANDOVER
    } t_phase;

    typedef struct packed {
        logic [PORT_BC_W-1:0] b;
        logic [PORT_D_W-1:0]  d;
        logic [PORT_BC_W-1:0] c;
    } t_ports;

    // What the blinkers need to know about the phase after this beat.
    typedef struct packed {
        logic run_a;
        logic run_b;
        logic cross_active;
        logic clr_lamp_a;
        logic clr_lamp_b;
    } t_phase_evt;

    function automatic t_ports phase_ports(input t_phase ph);
        t_ports p;
        case (ph)
            S_A_GREEN:  p = '{b: 6'b001001, d: 3'b100, c: 6'b100010};
            S_A_AMBER:  p = '{b: 6'b010010, d: 3'b010, c: 6'b100010};
            S_B_GREEN:  p = '{b: 6'b100100, d: 3'b001, c: 6'b001001};
            S_B_AMBER:  p = '{b: 6'b100100, d: 3'b010, c: 6'b001001};
            S_HANDOVER: p = '{b: 6'b100100, d: 3'b100, c: 6'b100010};
            default:    p = '{b: 6'b001001, d: 3'b100, c: 6'b100010};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### sv/tls_phase.sv
// Phase sequencer: millisecond down-counter, five-phase state machine and
// blinker run flags. Depends on tls_pkg.
`default_nettype none

module tls_phase (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_ms_tick,
    input  wire logic [tls_pkg::MS_W-1:0] i_green_ms,
    input  wire logic [tls_pkg::MS_W-1:0] i_amber_ms,
    output tls_pkg::t_ports              o_n_ports,
    output tls_pkg::t_phase_evt          o_evt
);
    import tls_pkg::*;

    t_phase            r_state, n_state;
    logic [MS_W-1:0]   r_ms_left, n_ms_left;
    logic              r_run_a, n_run_a;
    logic              r_run_b, n_run_b;
    logic              expire;
    logic [MS_W-1:0]   load_ms;
    logic              clr_a, clr_b;

    // The timer runs out when it steps from one to zero; a zero timer ignores ticks.
    assign expire = i_en && i_ms_tick && (r_ms_left == {{(MS_W-1){1'b0}}, 1'b1});

    always_comb begin
        n_state = r_state;
        if (expire) begin
            case (r_state)
                S_A_GREEN:  n_state = S_A_AMBER;
                S_A_AMBER:  n_state = S_B_GREEN;
                S_B_GREEN:  n_state = S_B_AMBER;
                S_B_AMBER:  n_state = S_HANDOVER;
                S_HANDOVER: n_state = S_A_GREEN;
                default:    n_state = r_state;
            endcase
        end
    end

    always_comb begin
        load_ms = i_green_ms;
        n_run_a = r_run_a;
        n_run_b = r_run_b;
        clr_a   = 1'b0;
        clr_b   = 1'b0;
        if (expire) begin
            case (r_state)
                S_A_GREEN: begin
                    load_ms = i_amber_ms;
                    n_run_a = 1'b0;
                    n_run_b = 1'b0;
                    clr_a   = 1'b1;
                end
                S_A_AMBER: begin
                    n_run_b = 1'b1;
                end
                S_B_GREEN: begin
                    load_ms = i_amber_ms;
                    n_run_b = 1'b0;
                    clr_b   = 1'b1;
                end
                S_B_AMBER, S_HANDOVER: begin
                    n_run_a = 1'b1;
                end
                default: begin
                    load_ms = i_green_ms;
                end
            endcase
        end
    end

    always_comb begin
        n_ms_left = r_ms_left;
        if (expire) begin
            n_ms_left = load_ms;
        end else if (i_en && i_ms_tick && (r_ms_left != '0)) begin
            n_ms_left = r_ms_left - {{(MS_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_A_GREEN;
            r_ms_left <= GREEN_MS_RST;
            r_run_a   <= 1'b1;
            r_run_b   <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_ms_left <= n_ms_left;
            r_run_a   <= n_run_a;
            r_run_b   <= n_run_b;
        end
    end

    assign o_n_ports          = phase_ports(n_state);
    assign o_evt.run_a        = n_run_a;
    assign o_evt.run_b        = n_run_b;
    assign o_evt.cross_active = (n_state == S_A_AMBER) || (n_state == S_B_GREEN)
                                || (n_state == S_B_AMBER);
    assign o_evt.clr_lamp_a   = clr_a;
    assign o_evt.clr_lamp_b   = clr_b;

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_state) && $stable(r_ms_left)))
        else $error("phase state moved without a beat");

    a_state_moves_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != n_state) |-> expire)
        else $error("phase change without timer expiry");

    a_amber_stops_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (expire && r_state == S_A_GREEN) |=> (!r_run_a && !r_run_b))
        else $error("blinkers still run after road A amber entry");

endmodule

`default_nettype wire

### sv/tls_blink.sv
// Two blinker dividers counting slow ticks, with their toggles and lamps.
// Depends on tls_pkg and on the phase events from tls_phase.
`default_nettype none

module tls_blink (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_slow_tick,
    input  wire logic [tls_pkg::DIV_W-1:0] i_compare,
    input  wire tls_pkg::t_phase_evt      i_evt,
    output logic                          o_n_lamp_a,
    output logic                          o_n_lamp_b
);
    import tls_pkg::*;

    logic [DIV_W-1:0] r_cnt_a, n_cnt_a;
    logic [DIV_W-1:0] r_cnt_b, n_cnt_b;
    logic             r_tog_a, n_tog_a;
    logic             r_tog_b, n_tog_b;
    logic             r_lamp_a, n_lamp_a;
    logic             r_lamp_b, n_lamp_b;
    logic             step_a, step_b;
    logic             hit_a, hit_b;

    assign step_a = i_en && i_slow_tick && i_evt.run_a;
    assign step_b = i_en && i_slow_tick && i_evt.run_b;
    assign hit_a  = step_a && (r_cnt_a == i_compare);
    assign hit_b  = step_b && (r_cnt_b == i_compare);

    always_comb begin
        n_cnt_a  = r_cnt_a;
        n_tog_a  = r_tog_a;
        n_lamp_a = i_evt.clr_lamp_a ? 1'b0 : r_lamp_a;
        if (hit_a) begin
            n_cnt_a  = '0;
            n_tog_a  = !r_tog_a;
            n_lamp_a = !r_tog_a;
        end else if (step_a) begin
            n_cnt_a = r_cnt_a + {{(DIV_W-1){1'b0}}, 1'b1};
        end
    end

    // Lamp B only flashes in the crossing phases (road A amber, road B green and amber); elsewhere a hit darkens it.
    always_comb begin
        n_cnt_b  = r_cnt_b;
        n_tog_b  = r_tog_b;
        n_lamp_b = i_evt.clr_lamp_b ? 1'b0 : r_lamp_b;
        if (hit_b) begin
            n_cnt_b = '0;
            if (i_evt.cross_active) begin
                n_tog_b  = !r_tog_b;
                n_lamp_b = !r_tog_b;
            end else begin
                n_lamp_b = 1'b0;
            end
        end else if (step_b) begin
            n_cnt_b = r_cnt_b + {{(DIV_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_tog_a  <= 1'b0;
            r_tog_b  <= 1'b0;
            r_lamp_a <= 1'b0;
            r_lamp_b <= 1'b0;
        end else begin
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_tog_a  <= n_tog_a;
            r_tog_b  <= n_tog_b;
            r_lamp_a <= n_lamp_a;
            r_lamp_b <= n_lamp_b;
        end
    end

    assign o_n_lamp_a = n_lamp_a;
    assign o_n_lamp_b = n_lamp_b;

    a_lamp_b_needs_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_lamp_b && !r_lamp_b) |-> i_evt.cross_active)
        else $error("lamp B lit outside the road B phases");

    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_evt.run_a) |=> $stable(r_cnt_a))
        else $error("stopped divider A moved");

    a_lamp_follows_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_a |=> (r_lamp_a == r_tog_a))
        else $error("lamp A does not follow its toggle");

endmodule

`default_nettype wire

### sv/two_way_traffic_light_sequencer.sv
// Two-way traffic light sequencer, top level.
// Datapath: a taken input beat passes through the input register, then the result
// register. Throughput: one beat per cycle while the output is not stalled.
// Reset is synchronous and active low; afterwards the phase is road A green with
// 4000 ms loaded and both blinkers running. Depends on tls_pkg, tls_phase, tls_blink.
`default_nettype none

module two_way_traffic_light_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_ms_tick,
    input  wire logic                          i_slow_tick,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tls_pkg::PORT_BC_W-1:0]      o_lamps_b,
    output logic [tls_pkg::PORT_D_W-1:0]       o_lamps_d,
    output logic [tls_pkg::PORT_BC_W-1:0]      o_lamps_c,
    output logic                               o_blink_lamp_a,
    output logic                               o_blink_lamp_b,
    input  wire logic                          i_cfg_we,
    input  wire logic [tls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tls_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tls_pkg::*;

    logic [MS_W-1:0]  r_green_ms;
    logic [MS_W-1:0]  r_amber_ms;
    logic [DIV_W-1:0] r_blink_compare;

    logic             r_in_valid;
    logic             r_ms_tick;
    logic             r_slow_tick;
    logic             advance;

    t_ports           n_ports;
    t_phase_evt       evt;
    logic             n_lamp_a;
    logic             n_lamp_b;

    logic             r_out_valid;
    t_ports           r_ports;
    logic             r_lamp_a;
    logic             r_lamp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_ms      <= GREEN_MS_RST;
            r_amber_ms      <= AMBER_MS_RST;
            r_blink_compare <= BLINK_COMPARE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GREEN_MS:      r_green_ms      <= i_cfg_data;
                CFG_AMBER_MS:      r_amber_ms      <= i_cfg_data;
                CFG_BLINK_COMPARE: r_blink_compare <= i_cfg_data[DIV_W-1:0];
                default:           r_green_ms      <= r_green_ms;
            endcase
        end
    end

    // A beat leaves the input register whenever the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_ms_tick   <= i_ms_tick;
            r_slow_tick <= i_slow_tick;
        end
    end

    tls_phase u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_ms_tick  (r_ms_tick),
        .i_green_ms (r_green_ms),
        .i_amber_ms (r_amber_ms),
        .o_n_ports  (n_ports),
        .o_evt      (evt)
    );

    tls_blink u_blink (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_slow_tick (r_slow_tick),
        .i_compare   (r_blink_compare),
        .i_evt       (evt),
        .o_n_lamp_a  (n_lamp_a),
        .o_n_lamp_b  (n_lamp_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ports  <= n_ports;
            r_lamp_a <= n_lamp_a;
            r_lamp_b <= n_lamp_b;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_lamps_b      = r_ports.b;
    assign o_lamps_d      = r_ports.d;
    assign o_lamps_c      = r_ports.c;
    assign o_blink_lamp_a = r_lamp_a;
    assign o_blink_lamp_b = r_lamp_b;

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("beat lost between input and result register");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_ports)
                                          && $stable(r_lamp_a) && $stable(r_lamp_b)))
        else $error("stalled result beat changed");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline can move");

    a_lamp_d_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_lamps_d))
        else $error("second lamp port not one hot");

endmodule

`default_nettype wire

### verif/two_way_traffic_light_sequencer_tb.sv
// Self-checking testbench for the two-way traffic light sequencer.
// Predicts every result beat from its own model of phases and blinkers and checks
// each one in order. Depends on tls_pkg and two_way_traffic_light_sequencer.

module two_way_traffic_light_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tls_pkg::*;

    localparam int unsigned RESULT_LATENCY = 2;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned LONG_HOLD      = 80;

    // Phase codes of the bench model, a main phase and a crossing sub-phase: the value names the phase in progress.
    localparam logic [1:0] MAIN_HANDOVER = 2'd0;
    localparam logic [1:0] MAIN_A_GREEN  = 2'd1;
    localparam logic [1:0] MAIN_CROSS    = 2'd2;
    localparam logic [1:0] CROSS_A_AMBER = 2'd0;
    localparam logic [1:0] CROSS_B_GREEN = 2'd1;
    localparam logic [1:0] CROSS_B_AMBER = 2'd2;

    localparam logic [PORT_BC_W-1:0] PAT_B_ROAD_A_GREEN = 6'b001001;
    localparam logic [PORT_BC_W-1:0] PAT_B_ROAD_A_AMBER = 6'b010010;
    localparam logic [PORT_BC_W-1:0] PAT_B_ROAD_B_TURN  = 6'b100100;
    localparam logic [PORT_D_W-1:0]  PAT_D_RED          = 3'b100;
    localparam logic [PORT_D_W-1:0]  PAT_D_AMBER        = 3'b010;
    localparam logic [PORT_D_W-1:0]  PAT_D_GREEN        = 3'b001;
    localparam logic [PORT_BC_W-1:0] PAT_C_ROAD_A_TURN  = 6'b100010;
    localparam logic [PORT_BC_W-1:0] PAT_C_ROAD_B_TURN  = 6'b001001;

    localparam int unsigned IDLE_NONE  = 0;
    localparam int unsigned IDLE_LIGHT = 1;
    localparam int unsigned IDLE_HEAVY = 2;

    typedef struct packed {
        logic [PORT_BC_W-1:0] b;
        logic [PORT_D_W-1:0]  d;
        logic [PORT_BC_W-1:0] c;
        logic                 blink_a;
        logic                 blink_b;
    } t_lamp_beat;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 src_valid     = 1'b0;
    logic                 src_ms_tick   = 1'b0;
    logic                 src_slow_tick = 1'b0;
    logic                 sink_stall    = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_GREEN_MS;
    logic [CFG_DAT_W-1:0] cfg_data      = '0;

    logic                 dut_in_stall;
    logic                 dut_out_valid;
    logic [PORT_BC_W-1:0] dut_lamps_b;
    logic [PORT_D_W-1:0]  dut_lamps_d;
    logic [PORT_BC_W-1:0] dut_lamps_c;
    logic                 dut_blink_a;
    logic                 dut_blink_b;

    two_way_traffic_light_sequencer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (src_valid),
        .o_in_stall     (dut_in_stall),
        .i_ms_tick      (src_ms_tick),
        .i_slow_tick    (src_slow_tick),
        .o_out_valid    (dut_out_valid),
        .i_out_stall    (sink_stall),
        .o_lamps_b      (dut_lamps_b),
        .o_lamps_d      (dut_lamps_d),
        .o_lamps_c      (dut_lamps_c),
        .o_blink_lamp_a (dut_blink_a),
        .o_blink_lamp_b (dut_blink_b),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Sequencer state as predicted; starts as the block leaves reset.
    logic [MS_W-1:0]  green_time = GREEN_MS_RST;
    logic [MS_W-1:0]  amber_time = AMBER_MS_RST;
    logic [DIV_W-1:0] blink_cmp  = BLINK_COMPARE_RST;
    logic [1:0]       main_ph    = MAIN_A_GREEN;
    logic [1:0]       cross_ph   = CROSS_A_AMBER;
    logic [MS_W-1:0]  ms_left    = GREEN_MS_RST;
    logic [DIV_W-1:0] div_a      = '0;
    logic [DIV_W-1:0] div_b      = '0;
    logic             run_a      = 1'b1;
    logic             run_b      = 1'b1;
    logic             tog_a      = 1'b0;
    logic             tog_b      = 1'b0;
    t_lamp_beat       lamps_now  = '{b: PAT_B_ROAD_A_GREEN, d: PAT_D_RED,
                                     c: PAT_C_ROAD_A_TURN, blink_a: 1'b0, blink_b: 1'b0};

    t_lamp_beat  expected_lamps_q[$];
    int unsigned error_count       = 0;
    int unsigned idle_mode         = IDLE_NONE;
    int unsigned long_hold_cycles  = 0;

    task automatic set_lamp_ports(input logic [PORT_BC_W-1:0] b, input logic [PORT_D_W-1:0] d,
                                  input logic [PORT_BC_W-1:0] c);
        lamps_now.b = b;
        lamps_now.d = d;
        lamps_now.c = c;
    endtask

    task automatic enter_next_phase();
        case (main_ph)
            MAIN_HANDOVER: begin
                set_lamp_ports(PAT_B_ROAD_A_GREEN, PAT_D_RED, PAT_C_ROAD_A_TURN);
                ms_left = green_time;
                main_ph = MAIN_A_GREEN;
                run_a   = 1'b1;
            end
            MAIN_A_GREEN: begin
                set_lamp_ports(PAT_B_ROAD_A_AMBER, PAT_D_AMBER, PAT_C_ROAD_A_TURN);
                ms_left = amber_time;
                main_ph = MAIN_CROSS;
                cross_ph = CROSS_A_AMBER;
                run_a = 1'b0;
                run_b = 1'b0;
                lamps_now.blink_a = 1'b0;
            end
            MAIN_CROSS: begin
                case (cross_ph)
                    CROSS_A_AMBER: begin
                        set_lamp_ports(PAT_B_ROAD_B_TURN, PAT_D_GREEN, PAT_C_ROAD_B_TURN);
                        ms_left  = green_time;
                        cross_ph = CROSS_B_GREEN;
                        run_b    = 1'b1;
                    end
                    CROSS_B_GREEN: begin
                        set_lamp_ports(PAT_B_ROAD_B_TURN, PAT_D_AMBER, PAT_C_ROAD_B_TURN);
                        ms_left  = amber_time;
                        cross_ph = CROSS_B_AMBER;
                        run_b    = 1'b0;
                        lamps_now.blink_b = 1'b0;
                    end
                    CROSS_B_AMBER: begin
                        set_lamp_ports(PAT_B_ROAD_B_TURN, PAT_D_RED, PAT_C_ROAD_A_TURN);
                        ms_left  = green_time;
                        cross_ph = CROSS_A_AMBER;
                        main_ph  = MAIN_HANDOVER;
                        run_a    = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // The millisecond tick and any phase change come first; the blinkers then see
    // the updated run flags and phase.
    task automatic predict_lamps(input logic ms, input logic slow);
        if (ms && ms_left != '0) begin
            ms_left = ms_left - MS_W'(1);
            if (ms_left == '0)
                enter_next_phase();
        end
        if (slow) begin
            if (run_a) begin
                if (div_a == blink_cmp) begin
                    div_a = '0;
                    tog_a = ~tog_a;
                    lamps_now.blink_a = tog_a;
                end else begin
                    div_a = div_a + DIV_W'(1);
                end
            end
            if (run_b) begin
                if (div_b == blink_cmp) begin
                    div_b = '0;
                    if (main_ph == MAIN_CROSS) begin
                        tog_b = ~tog_b;
                        lamps_now.blink_b = tog_b;
                    end else begin
                        lamps_now.blink_b = 1'b0;
                    end
                end else begin
                    div_b = div_b + DIV_W'(1);
                end
            end
        end
        expected_lamps_q.push_back(lamps_now);
    endtask

    function automatic int unsigned draw_gap();
        case (idle_mode)
            IDLE_LIGHT: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
            IDLE_HEAVY: return $urandom_range(0, 15);
            default:    return 0;
        endcase
    endfunction

    task automatic send_beat(input logic ms, input logic slow);
        int unsigned gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            src_valid     = 1'b0;
            src_ms_tick   = 1'($urandom_range(0, 1));
            src_slow_tick = 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        src_valid     = 1'b1;
        src_ms_tick   = ms;
        src_slow_tick = slow;
        do @(posedge i_clk); while (dut_in_stall !== 1'b0);
        predict_lamps(ms, slow);
    endtask

    // Lowers valid before the next edge, then waits for every outstanding result.
    task automatic wait_drained();
        @(negedge i_clk);
        src_valid = 1'b0;
        while (expected_lamps_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] value);
        wait_drained();
        repeat (RESULT_LATENCY + 2) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_GREEN_MS:      green_time = value;
            CFG_AMBER_MS:      amber_time = value;
            CFG_BLINK_COMPARE: blink_cmp  = value[DIV_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver: draws a stall length per beat; a requested long hold takes precedence.
    initial begin : result_sink
        int unsigned hold;
        forever begin
            @(negedge i_clk);
            if (long_hold_cycles != 0) begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                hold = draw_gap();
            end
            if (hold != 0) begin
                sink_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
                sink_stall = 1'b0;
            end
            do @(posedge i_clk); while (!(dut_out_valid === 1'b1 && sink_stall === 1'b0));
        end
    end

    always @(posedge i_clk) begin : lamp_checker
        t_lamp_beat got;
        t_lamp_beat want;
        if (i_rst_n && dut_out_valid === 1'b1 && sink_stall === 1'b0) begin
            got = '{b: dut_lamps_b, d: dut_lamps_d, c: dut_lamps_c,
                    blink_a: dut_blink_a, blink_b: dut_blink_b};
            if (expected_lamps_q.size() == 0) begin
                $display("%0t: result beat with none expected, actual b=%h d=%h c=%h a=%b b=%b",
                         $time, got.b, got.d, got.c, got.blink_a, got.blink_b);
                error_count++;
            end else begin
                want = expected_lamps_q.pop_front();
                if (got !== want) begin
                    $display("%0t: lamp mismatch, expected b=%h d=%h c=%h a=%b b=%b, %s%h d=%h c=%h a=%b b=%b",
                             $time, want.b, want.d, want.c, want.blink_a, want.blink_b,
                             "actual b=", got.b, got.d, got.c, got.blink_a, got.blink_b);
                    error_count++;
                end
            end
        end
    end

    task automatic test_power_on_state();
        idle_mode = IDLE_LIGHT;
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b1);
    endtask

    // The power-on green is 4000 ms long whatever the registers say, so it is run
    // out back to back with the shortest settings already loaded for what follows.
    task automatic test_leave_power_on_green();
        write_reg(CFG_GREEN_MS, 16'd1);
        write_reg(CFG_AMBER_MS, 16'd1);
        write_reg(CFG_BLINK_COMPARE, 16'd0);
        idle_mode = IDLE_NONE;
        while (ms_left > 1)
            send_beat(1'b1, 1'($urandom_range(0, 1)));
    endtask

    // Most beats carry both ticks, so most phase changes meet a blinker match.
    task automatic test_phase_walk();
        idle_mode = IDLE_HEAVY;
        repeat (6) send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b1, 1'b0);
        repeat (4) send_beat(1'b1, 1'b1);
    endtask

    // Lower the compare value under the running count: the divider must wrap past
    // its top before it matches again.
    task automatic test_compare_below_count();
        write_reg(CFG_BLINK_COMPARE, 16'd255);
        idle_mode = IDLE_LIGHT;
        while (main_ph != MAIN_A_GREEN)
            send_beat(1'b1, 1'b0);
        repeat (120) send_beat(1'b0, 1'b1);
        write_reg(CFG_BLINK_COMPARE, 16'd20);
        repeat (160) send_beat(1'b0, 1'b1);
    endtask

    task automatic test_random_settings();
        logic [CFG_DAT_W-1:0] cmp;
        for (int s = 0; s < 8; s++) begin
            if (s == 0) begin
                write_reg(CFG_GREEN_MS, 16'd1);
                write_reg(CFG_AMBER_MS, 16'd1);
                write_reg(CFG_BLINK_COMPARE, 16'd0);
                idle_mode = IDLE_NONE;
            end else begin
                case ($urandom_range(0, 2))
                    0:       cmp = 16'd255;
                    1:       cmp = 16'd0;
                    default: cmp = CFG_DAT_W'($urandom_range(0, 7));
                endcase
                write_reg(CFG_GREEN_MS, CFG_DAT_W'($urandom_range(1, 40)));
                write_reg(CFG_AMBER_MS, CFG_DAT_W'($urandom_range(1, 20)));
                write_reg(CFG_BLINK_COMPARE, cmp);
                idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
            end
            repeat (190) send_beat($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        long_hold_cycles = LONG_HOLD;
        repeat (40) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_drained();
        repeat (10) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_upper_extremes();
        write_reg(CFG_GREEN_MS, 16'hFFFF);
        write_reg(CFG_AMBER_MS, 16'hFFFF);
        write_reg(CFG_BLINK_COMPARE, 16'd255);
        idle_mode = IDLE_HEAVY;
        repeat (40) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_power_on_state();
        test_leave_power_on_green();
        test_phase_walk();
        test_compare_below_count();
        test_random_settings();
        test_backpressure();
        test_upper_extremes();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
